>>> hw/rtl/cfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfr_pkg - shared types for the checksummed frame receiver
// Result kinds, register indexes, stream widths and the command and status
// groups that pass between controller and datapath.
// ---------------------------------------------------------------------------
package cfr_pkg;

	// Result kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_SUM_ERR = 2'd2,
		KIND_END_ERR = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int INDEX_W     = 6;
	localparam int POS_W       = 9;
	localparam int MAX_RESULTS = 64;

	// Controller to datapath commands
	typedef struct packed {
		logic  start_frame;   // clear position and sum
		logic  take_cmd;      // capture command byte
		logic  take_len;      // capture length byte
		logic  take_payload;  // store and sum a payload byte that fits the store, advance position
		logic  load_result;   // load a single result into the output register
		kind_t result_kind;
		logic  start_emit;    // rewind the read index
		logic  issue_read;    // read the store at the read index
		logic  load_data;     // load the read byte into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic start_hit;   // incoming byte equals the start marker
		logic end_hit;     // incoming byte equals the end marker
		logic sum_hit;     // incoming byte equals the running sum
		logic pos_lt_len;  // position still inside the payload
		logic len_zero;    // declared length is zero
		logic out_free;    // output register can take a result this cycle
		logic emit_last;   // read index is on the final stored byte
	} sts_t;

endpackage

>>> hw/rtl/checksummed_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// checksummed_frame_receiver - delimited frame parser with 8-bit sum check
// Parses start, command, length, payload, checksum and end bytes and emits
// the payload as a run, or one status result.
// ---------------------------------------------------------------------------
// One received byte is taken per cycle while a frame is being read; the
// checksum and end bytes are taken only once the output register is free.
// After a good end byte the stored payload goes out one result at a time,
// each by a store read and then an output register load once that register
// is free, and no input byte is taken until the run's last result is loaded.
// At most min(length, BUFFER_DEPTH, 64) payload results come from one frame.
module checksummed_frame_receiver #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] command, [15:8] length, [21:16] index,
	                               // [29:22] data_byte, [31:30] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	cfr_pkg::cmd_t cmd;
	cfr_pkg::sts_t sts;

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfr_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// No input is taken during the payload run
	a_no_input_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue_read || cmd.load_data) |-> !s_tready)
		else $error("input request taken during payload run");

	// A result is only loaded into a free output register
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_result || cmd.load_data) |-> sts.out_free)
		else $error("result loaded over a pending request");

	// Status results always close their own run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != cfr_pkg::KIND_DATA)) |-> m_tlast)
		else $error("status result without last mark");

endmodule

>>> hw/rtl/cfr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfr_ctrl - frame receiver controller
// Walks the frame fields, decides results and sequences the payload run.
// ---------------------------------------------------------------------------
module cfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  cfr_pkg::sts_t sts,
	output cfr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_LEN,
		ST_BODY,
		ST_END,
		ST_RD,
		ST_LD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	// Hold off input while the checksum or end byte finds the output register busy, and during the payload run
	always_comb begin
		case (state_q)
			ST_IDLE, ST_CMD, ST_LEN: s_tready = 1'b1;
			ST_BODY:                 s_tready = sts.pos_lt_len | sts.out_free;
			ST_END:                  s_tready = sts.out_free;
			default:                 s_tready = 1'b0;
		endcase
	end

	assign acc = s_tvalid & s_tready;

	// Decode commands and next state
	always_comb begin
		cmd             = '0;
		cmd.result_kind = cfr_pkg::KIND_DATA;
		state_d         = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && sts.start_hit) begin
					cmd.start_frame = 1'b1;
					state_d         = ST_CMD;
				end
			end
			ST_CMD: begin
				if (acc) begin
					cmd.take_cmd = 1'b1;
					state_d      = ST_LEN;
				end
			end
			ST_LEN: begin
				if (acc) begin
					cmd.take_len = 1'b1;
					state_d      = ST_BODY;
				end
			end
			ST_BODY: begin
				if (acc) begin
					if (sts.pos_lt_len) begin
						cmd.take_payload = 1'b1;
					end else if (!sts.sum_hit) begin
						cmd.load_result = 1'b1;
						cmd.result_kind = cfr_pkg::KIND_SUM_ERR;
						state_d         = ST_IDLE;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				if (acc) begin
					if (!sts.end_hit) begin
						cmd.load_result = 1'b1;
						cmd.result_kind = cfr_pkg::KIND_END_ERR;
						state_d         = ST_IDLE;
					end else if (sts.len_zero) begin
						cmd.load_result = 1'b1;
						cmd.result_kind = cfr_pkg::KIND_EMPTY;
						state_d         = ST_IDLE;
					end else begin
						cmd.start_emit = 1'b1;
						state_d        = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.issue_read = 1'b1;
				state_d        = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					state_d       = sts.emit_last ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/cfr_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfr_dpath - frame receiver datapath
// Marker registers, frame fields, running sum, payload store and the
// output register.
// ---------------------------------------------------------------------------
module cfr_dpath #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfr_pkg::cmd_t                       cmd,
	output cfr_pkg::sts_t                       sts,
	input  logic [cfr_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [7:0]                          cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cfr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [1:0]                          m_tuser,
	output logic                                m_tlast
);

	localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CAP = (BUFFER_DEPTH < cfr_pkg::MAX_RESULTS) ?
		BUFFER_DEPTH : cfr_pkg::MAX_RESULTS;

	logic [7:0]                   start_q;
	logic [7:0]                   end_q;
	logic [cfr_pkg::POS_W-1:0]    pos_q;
	logic [7:0]                   sum_q;
	logic [7:0]                   fcmd_q;
	logic [7:0]                   flen_q;
	logic [7:0]                   mem [BUFFER_DEPTH];
	logic [7:0]                   rdata_q;
	logic [cfr_pkg::INDEX_W-1:0]  rd_idx_q;

	logic                         out_valid_q;
	cfr_pkg::kind_t               out_kind_q;
	logic [7:0]                   out_cmd_q;
	logic [7:0]                   out_len_q;
	logic [cfr_pkg::INDEX_W-1:0]  out_idx_q;
	logic [7:0]                   out_data_q;
	logic                         out_last_q;

	logic [cfr_pkg::POS_W-1:0]    len2;
	logic [cfr_pkg::POS_W-1:0]    slot;
	logic                         slot_ok;
	logic [cfr_pkg::POS_W-1:0]    count;

	// Compare incoming byte and frame position
	assign len2    = cfr_pkg::POS_W'(flen_q) + cfr_pkg::POS_W'(2);
	assign slot    = pos_q - cfr_pkg::POS_W'(2);
	assign slot_ok = slot < cfr_pkg::POS_W'(BUFFER_DEPTH);
	assign count   = (cfr_pkg::POS_W'(flen_q) < cfr_pkg::POS_W'(CAP)) ?
		cfr_pkg::POS_W'(flen_q) : cfr_pkg::POS_W'(CAP);

	assign sts.start_hit  = (s_tdata == start_q);
	assign sts.end_hit    = (s_tdata == end_q);
	assign sts.sum_hit    = (s_tdata == sum_q);
	assign sts.pos_lt_len = (pos_q < len2);
	assign sts.len_zero   = (flen_q == 8'd0);
	assign sts.out_free   = ~out_valid_q | m_tready;
	assign sts.emit_last  = (cfr_pkg::POS_W'(rd_idx_q) + cfr_pkg::POS_W'(1) == count);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'hA5;
			end_q   <= 8'h5A;
		end else if (cfg_we) begin
			case (cfg_index)
				cfr_pkg::CFG_START_MARKER: start_q <= cfg_data;
				cfr_pkg::CFG_END_MARKER:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame position and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd.start_frame) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd.take_cmd || cmd.take_len) begin
			pos_q <= pos_q + cfr_pkg::POS_W'(1);
			sum_q <= sum_q + s_tdata;
		end else if (cmd.take_payload) begin
			pos_q <= pos_q + cfr_pkg::POS_W'(1);
			if (slot_ok) begin
				sum_q <= sum_q + s_tdata;
			end
		end
	end

	// Capture frame header fields
	always_ff @(posedge clk) begin
		if (cmd.take_cmd) begin
			fcmd_q <= s_tdata;
		end
		if (cmd.take_len) begin
			flen_q <= s_tdata;
		end
	end

	// Payload store: write in the body, read during the run
	always_ff @(posedge clk) begin
		if (cmd.take_payload && slot_ok) begin
			mem[AW'(slot)] <= s_tdata;
		end
		if (cmd.issue_read) begin
			rdata_q <= mem[AW'(rd_idx_q)];
		end
	end

	// Advance the read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.start_emit) begin
			rd_idx_q <= '0;
		end else if (cmd.load_data) begin
			rd_idx_q <= rd_idx_q + cfr_pkg::INDEX_W'(1);
		end
	end

	// Output register: set on load, drop when the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_kind_q <= cmd.result_kind;
			out_cmd_q  <= fcmd_q;
			out_len_q  <= flen_q;
			out_idx_q  <= '0;
			out_data_q <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.load_data) begin
			out_kind_q <= cfr_pkg::KIND_DATA;
			out_cmd_q  <= fcmd_q;
			out_len_q  <= flen_q;
			out_idx_q  <= rd_idx_q;
			out_data_q <= rdata_q;
			out_last_q <= sts.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_data_q, out_idx_q, out_len_q, out_cmd_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
